FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the integer parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: sv/aip_pkg.sv
// Package of the integer parser: widths, phase codes, character codes and the state type.
package aip_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned OUT_BITS   = 64;

  // Parse phase codes.
  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_ZERO = 3'd1;
  localparam logic [2:0] PH_HEX  = 3'd2;
  localparam logic [2:0] PH_DEC  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CASE_GAP  = 8'h20;  // 'a' - 'A'
  localparam logic [7:0] HEX_GAP   = 8'd7;   // 'A' - '9' - 1

  typedef struct packed {
    logic [2:0]            phase;
    logic                  neg;
    logic [VALUE_BITS-1:0] acc;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, neg: 1'b0, acc: '0};

endpackage

FILE: sv/aip_step.sv
// Combinational parse step: next state and result for one string byte.
module aip_step (
  input  aip_pkg::parse_state_t        cur_i,
  input  logic [7:0]                   char_i,
  output aip_pkg::parse_state_t        nxt_o,
  output logic                         emit_o,
  output logic signed [aip_pkg::OUT_BITS-1:0] value_o
);

  localparam int unsigned VB = aip_pkg::VALUE_BITS;

  logic [VB-1:0] times10;
  logic [VB-1:0] dec_acc;
  logic [VB-1:0] hex_acc;
  logic [VB-1:0] final_v;
  logic          is_dec;
  logic [3:0]    dec_digit;
  logic [7:0]    folded;
  logic          is_hex;
  logic [7:0]    hex_raw;
  logic [3:0]    hex_digit;

  assign is_dec    = (char_i >= aip_pkg::CH_ZERO) && (char_i <= aip_pkg::CH_NINE);
  assign dec_digit = 4'(char_i - aip_pkg::CH_ZERO);
  assign times10   = {cur_i.acc[VB-4:0], 3'b000} + {cur_i.acc[VB-2:0], 1'b0};
  assign dec_acc   = times10 + {{(VB-4){1'b0}}, dec_digit};

  always_comb begin
    folded = char_i;
    if ((char_i >= aip_pkg::CH_LO_A) && (char_i <= aip_pkg::CH_LO_F)) begin
      folded = char_i - aip_pkg::CASE_GAP;
    end
    is_hex  = 1'b1;
    hex_raw = folded - aip_pkg::CH_ZERO;
    if ((folded >= aip_pkg::CH_UP_A) && (folded <= aip_pkg::CH_UP_F)) begin
      hex_raw = folded - aip_pkg::CH_ZERO - aip_pkg::HEX_GAP;
    end else if (!((folded >= aip_pkg::CH_ZERO) && (folded <= aip_pkg::CH_NINE))) begin
      is_hex = 1'b0;
    end
  end

  assign hex_digit = hex_raw[3:0];
  assign hex_acc   = {cur_i.acc[VB-5:0], hex_digit};
  assign final_v   = cur_i.neg ? (VB'(0) - cur_i.acc) : cur_i.acc;
  assign value_o   = aip_pkg::OUT_BITS'($signed(final_v));

  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    if (char_i == aip_pkg::CH_NUL) begin
      emit_o = 1'b1;
      nxt_o  = aip_pkg::STATE_RESET;
    end else begin
      case (cur_i.phase)
        aip_pkg::PH_LEAD: begin
          if (char_i == aip_pkg::CH_MINUS) begin
            nxt_o.neg = !cur_i.neg;
          end else if ((char_i == aip_pkg::CH_PLUS) || (char_i <= aip_pkg::CH_SPACE)) begin
            nxt_o = cur_i;
          end else if (char_i == aip_pkg::CH_DOLLAR) begin
            nxt_o.phase = aip_pkg::PH_HEX;
          end else if (char_i == aip_pkg::CH_ZERO) begin
            nxt_o.acc   = '0;
            nxt_o.phase = aip_pkg::PH_ZERO;
          end else if (is_dec) begin
            nxt_o.acc   = dec_acc;
            nxt_o.phase = aip_pkg::PH_DEC;
          end else begin
            nxt_o.phase = aip_pkg::PH_DONE;
          end
        end
        aip_pkg::PH_ZERO, aip_pkg::PH_DEC: begin
          if ((cur_i.phase == aip_pkg::PH_ZERO) &&
              ((char_i == aip_pkg::CH_LO_X) || (char_i == aip_pkg::CH_UP_X))) begin
            nxt_o.phase = aip_pkg::PH_HEX;
          end else if (is_dec) begin
            nxt_o.acc   = dec_acc;
            nxt_o.phase = aip_pkg::PH_DEC;
          end else begin
            nxt_o.phase = aip_pkg::PH_DONE;
          end
        end
        aip_pkg::PH_HEX: begin
          if (is_hex) begin
            nxt_o.acc = hex_acc;
          end else begin
            nxt_o.phase = aip_pkg::PH_DONE;
          end
        end
        default: begin
          nxt_o = cur_i;
        end
      endcase
    end
  end

endmodule

FILE: sv/ascii_integer_parser.sv
// Top level of the integer parser: input register, parse state, result register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  char_code_i     (8 bits)
//   out      source     out_valid_o/out_stall_i parsed_value_o (64 bits, signed)
//
// One byte is accepted per cycle unless in_stall_o is raised. A byte waits in the
// input register and is then folded into the parse state by a single
// multiply-by-ten-and-add or shift. A NUL byte that moves on from the input register
// writes its value into the result register and sets its valid flag. Reset clears the
// parse state and both valid flags. A stalled result holds the pipeline only when the
// byte waiting in the input register is another NUL; all other bytes keep flowing
// under an output stall.
`include "assert_macros.svh"

module ascii_integer_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [63:0]  parsed_value_o
);

  // Input register: one byte waiting to be parsed.
  logic                  in_valid_q;
  logic [7:0]            in_char_q;

  // Parse state carried between bytes of one string.
  aip_pkg::parse_state_t state_q;
  aip_pkg::parse_state_t state_d;

  // Result register.
  logic                  out_valid_q;
  logic signed [63:0]    out_value_q;

  logic                  emit;
  logic signed [63:0]    value;
  logic                  advance;

  aip_step u_step (
    .cur_i   (state_q),
    .char_i  (in_char_q),
    .nxt_o   (state_d),
    .emit_o  (emit),
    .value_o (value)
  );

  // A terminator can only move on when the result register is free or being drained.
  assign advance    = in_valid_q && (!emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_char_q <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aip_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_value_q <= value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = out_value_q;

  // A terminator that moves on leaves the parser in its reset state.
  `ASSERT_HOLDS(a_nul_resets, clk_i, rst_ni, (advance && in_char_q == aip_pkg::CH_NUL) |=> (state_q == aip_pkg::STATE_RESET))
  // Non-terminator bytes never raise a result.
  `ASSERT_HOLDS(a_no_spurious, clk_i, rst_ni, (!out_valid_q && !(advance && emit)) |=> !out_valid_q)
  // The input side only stalls behind a held result.
  `ASSERT_HOLDS(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_q && out_stall_i && emit))

endmodule
